FILE: rtl/rlce_pkg.sv
// Shared constants for the rule list capture engine.
package rlce_pkg;

  localparam int WORD_BITS_DEF   = 64;
  localparam int MAX_RULES_DEF   = 32;
  localparam int MAX_SAMPLES_DEF = 65536;
  localparam int SLOT_BITS       = 5;
  localparam int QUEUE_DEPTH     = 4;

endpackage

FILE: rtl/rlce_in_if.sv
// Input word channel of the rule list capture engine.
interface rlce_in_if
  import rlce_pkg::*;
#(
  parameter int W  = WORD_BITS_DEF,
  parameter int SB = SLOT_BITS
);
  logic          valid;
  logic          ready;
  logic          column_start;
  logic [W-1:0]  start_mask;
  logic [SB-1:0] rule_slot;
  logic          first_word;
  logic [W-1:0]  truth_word;

  modport source (
    output valid, column_start, start_mask, rule_slot, first_word, truth_word,
    input  ready
  );
  modport sink (
    input  valid, column_start, start_mask, rule_slot, first_word, truth_word,
    output ready
  );
endinterface

FILE: rtl/rlce_out_if.sv
// Result word channel of the rule list capture engine.
interface rlce_out_if
  import rlce_pkg::*;
#(
  parameter int W  = WORD_BITS_DEF,
  parameter int CW = $clog2(MAX_SAMPLES_DEF + 1),
  parameter int RW = $clog2(WORD_BITS_DEF + 1)
);
  logic          valid;
  logic          ready;
  logic [W-1:0]  capture_word;
  logic [CW-1:0] rule_count;
  logic [RW-1:0] remaining_count;

  modport source (
    output valid, capture_word, rule_count, remaining_count,
    input  ready
  );
  modport sink (
    input  valid, capture_word, rule_count, remaining_count,
    output ready
  );
endinterface

FILE: rtl/rlce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rlce_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: rtl/rlce_queue.sv
// Small first-in first-out queue between the front and back sections.
module rlce_queue
  import rlce_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  parameter int PW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);
  logic [WIDTH-1:0] store [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      fill;

  assign not_full  = (fill != (PW+1)'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end
endmodule

FILE: rtl/rlce_front.sv
// Front section: takes input words, applies the uncaptured mask (or the start mask at a column start) and counts bits.
module rlce_front
  import rlce_pkg::*;
#(
  parameter int W  = WORD_BITS_DEF,
  parameter int MAX_RULES = MAX_RULES_DEF,
  parameter int RW = $clog2(W + 1),
  parameter int AW = $clog2(MAX_RULES),
  parameter int QW = W + 2 * RW + AW + 1
) (
  input  logic          clk,
  input  logic          rst,
  rlce_in_if.sink       rule,
  output logic          push,
  output logic [QW-1:0] push_data,
  input  logic          not_full
);
  localparam int SLOT_N = 2 ** SLOT_BITS;

  logic [W-1:0]  uncaptured;
  logic [W-1:0]  open_word;
  logic [W-1:0]  cap;
  logic [W-1:0]  rest;
  logic [AW-1:0] slot_tbl [0:SLOT_N-1];

  // Pairwise adder tree, log2(W) levels deep.
  function automatic logic [RW-1:0] ones_in(input logic [W-1:0] w);
    logic [RW-1:0] part [0:W-1];
    for (int i = 0; i < W; i++) begin
      part[i] = RW'(w[i]);
    end
    for (int s = 1; s < W; s = s * 2) begin
      for (int i = 0; i + s < W; i = i + 2 * s) begin
        part[i] = part[i] + part[i + s];
      end
    end
    return part[0];
  endfunction

  for (genvar v = 0; v < SLOT_N; v++) begin : g_slot
    assign slot_tbl[v] = AW'(v % MAX_RULES);
  end

  assign rule.ready = not_full;
  assign push       = rule.valid && not_full;
  assign open_word  = rule.column_start ? rule.start_mask : uncaptured;
  assign cap        = open_word & rule.truth_word;
  assign rest       = open_word & ~rule.truth_word;
  assign push_data  = {cap, ones_in(cap), ones_in(rest),
                       slot_tbl[rule.rule_slot], rule.first_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      uncaptured <= '0;
    end else if (push) begin
      uncaptured <= rest;
    end
  end
endmodule

FILE: rtl/rlce_back.sv
// Back section: updates the per-slot counts and holds the result register.
module rlce_back
  import rlce_pkg::*;
#(
  parameter int W  = WORD_BITS_DEF,
  parameter int MAX_RULES = MAX_RULES_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int RW = $clog2(W + 1),
  parameter int AW = $clog2(MAX_RULES),
  parameter int CW = $clog2(MAX_SAMPLES + 1),
  parameter int QW = W + 2 * RW + AW + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          not_empty,
  input  logic [QW-1:0] pop_data,
  output logic          pop,
  rlce_out_if.source    result
);
  logic [W-1:0]  q_cap;
  logic [RW-1:0] q_cap_ones;
  logic [RW-1:0] q_rest_ones;
  logic [AW-1:0] q_slot;
  logic          q_first;

  logic          b_valid;
  logic [W-1:0]  b_cap;
  logic [RW-1:0] b_cap_ones;
  logic [RW-1:0] b_rest_ones;
  logic [AW-1:0] b_slot;
  logic          b_first;
  logic          b_adv;

  logic          fwd_valid;
  logic [AW-1:0] fwd_slot;
  logic [CW-1:0] fwd_val;

  logic [CW-1:0] rdata;
  logic [CW-1:0] base;
  logic [CW:0]   sum;
  logic [CW-1:0] sat;

  logic          o_valid;
  logic [W-1:0]  o_cap;
  logic [CW-1:0] o_count;
  logic [RW-1:0] o_rest;

  assign {q_cap, q_cap_ones, q_rest_ones, q_slot, q_first} = pop_data;

  assign b_adv = b_valid && (!o_valid || result.ready);
  assign pop   = not_empty && (!b_valid || b_adv);

  rlce_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_RULES)
  ) u_counts (
    .clk   (clk),
    .we    (b_adv),
    .waddr (b_slot),
    .wdata (sat),
    .re    (pop),
    .raddr (q_slot),
    .rdata (rdata)
  );

  always_comb begin
    if (b_first) begin
      base = '0;
    end else if (fwd_valid && (fwd_slot == b_slot)) begin
      base = fwd_val;
    end else begin
      base = rdata;
    end
    sum = {1'b0, base} + (CW+1)'(b_cap_ones);
    sat = (sum > (CW+1)'(MAX_SAMPLES)) ? CW'(MAX_SAMPLES) : sum[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_cap       <= q_cap;
      b_cap_ones  <= q_cap_ones;
      b_rest_ones <= q_rest_ones;
      b_slot      <= q_slot;
      b_first     <= q_first;
    end
    if (b_adv) begin
      fwd_slot <= b_slot;
      fwd_val  <= sat;
      o_cap    <= b_cap;
      o_count  <= sat;
      o_rest   <= b_rest_ones;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      b_valid <= pop || (b_valid && !b_adv);
      o_valid <= b_adv || (o_valid && !result.ready);
      if (b_adv) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  assign result.valid           = o_valid;
  assign result.capture_word    = o_cap;
  assign result.rule_count      = o_count;
  assign result.remaining_count = o_rest;
endmodule

FILE: rtl/rule_list_capture_engine.sv
// Top level of the rule list capture engine.
// A word passes the queue, the back section's count stage and the result register in turn.
// Throughput: one word per cycle unless results stall, set by the count memory read and add.
// The four-entry queue lets the input keep flowing while results stall, until it fills.
// Reset clears the uncaptured word, the queue and all valid flags; slot counts are not cleared.
module rule_list_capture_engine
  import rlce_pkg::*;
#(
  parameter int WORD_BITS   = WORD_BITS_DEF,
  parameter int MAX_RULES   = MAX_RULES_DEF,
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rlce_in_if.sink    rule,
  rlce_out_if.source result
);
  localparam int RW = $clog2(WORD_BITS + 1);
  localparam int AW = $clog2(MAX_RULES);
  localparam int QW = WORD_BITS + 2 * RW + AW + 1;

  logic          push;
  logic [QW-1:0] push_data;
  logic          not_full;
  logic          pop;
  logic [QW-1:0] pop_data;
  logic          not_empty;

  rlce_front #(
    .W         (WORD_BITS),
    .MAX_RULES (MAX_RULES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .rule      (rule),
    .push      (push),
    .push_data (push_data),
    .not_full  (not_full)
  );

  rlce_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .not_full  (not_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  rlce_back #(
    .W           (WORD_BITS),
    .MAX_RULES   (MAX_RULES),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .result    (result)
  );
endmodule
